@@ src/tsd_pkg.sv @@
// Shared constants and control types for the temperature shift detector.
package tsd_pkg;

  localparam int WINDOW_LENGTH_DEF = 7;
  localparam int DAY_W             = 20;
  localparam int TEMP_W            = 16;
  localparam int MAX_DAY_SPAN      = 6;
  localparam int MIN_COUNT         = 4;
  localparam int THR_W             = 6;
  localparam logic [THR_W-1:0] THRESH_F = 6'd40;
  localparam logic [THR_W-1:0] THRESH_C = 6'd20;

  // controller to datapath
  typedef struct packed {
    logic load;    // take the offered item into the window
    logic step;    // examine one older entry
    logic finish;  // write the result into the output register
  } tsd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_en;   // window full after this item and reading nonzero
    logic gap_stop;  // entry under examination is too far back
    logic out_free;  // output register can take a result this cycle
  } tsd_status_t;

endpackage

@@ src/tsd_ctrl.sv @@
// Sequencer for the shift detector: accept, walk the window, deliver.
module tsd_ctrl #(
  parameter int WINDOW_LENGTH = tsd_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsd_pkg::tsd_status_t status,
  output tsd_pkg::tsd_cmd_t    cmd
);

  localparam int BACK_W = $clog2(WINDOW_LENGTH);
  localparam logic [BACK_W-1:0] BACK_LAST = BACK_W'(WINDOW_LENGTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state, state_next;
  logic [BACK_W-1:0] back, back_next;

  assign in_ready   = (state == ST_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.step   = (state == ST_WALK);
  assign cmd.finish = (state == ST_DONE) && status.out_free;

  always_comb begin
    state_next = state;
    back_next  = back;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          back_next  = BACK_W'(1);
          state_next = status.walk_en ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        back_next = back + BACK_W'(1);
        if (status.gap_stop || back == BACK_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      back  <= '0;
    end else begin
      state <= state_next;
      back  <= back_next;
    end
  end

endmodule

@@ src/tsd_datapath.sv @@
// Window storage, walk accumulator, threshold compare and output register.
module tsd_datapath #(
  parameter int WINDOW_LENGTH = tsd_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_data,
  input  logic [tsd_pkg::DAY_W-1:0]   day_number,
  input  logic [tsd_pkg::TEMP_W-1:0]  temperature,
  input  tsd_pkg::tsd_cmd_t            cmd,
  output tsd_pkg::tsd_status_t         status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        shift_found,
  output logic [tsd_pkg::DAY_W-1:0]   shift_day
);

  localparam int DAY_W  = tsd_pkg::DAY_W;
  localparam int TEMP_W = tsd_pkg::TEMP_W;
  localparam int THR_W_L = tsd_pkg::THR_W;
  localparam int PTR_W  = $clog2(WINDOW_LENGTH);
  localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
  localparam int CNT_W  = $clog2(WINDOW_LENGTH);
  localparam int SUM_W  = TEMP_W + CNT_W;
  localparam int CMP_W  = SUM_W + 1;
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW_LENGTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_LENGTH);

  logic [DAY_W-1:0]  win_days  [WINDOW_LENGTH];
  logic [TEMP_W-1:0] win_temps [WINDOW_LENGTH];

  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [FILL_W-1:0] fill_count;
  logic              fahrenheit_mode;
  logic [DAY_W-1:0]  day_r;
  logic [TEMP_W-1:0] temp_r;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count;

  logic [PTR_W-1:0]  prev_ptr;
  logic [DAY_W-1:0]  rd_day;
  logic [TEMP_W-1:0] rd_temp;
  logic [DAY_W:0]    gap;
  logic [THR_W_L-1:0] thr;
  logic [CMP_W-1:0]  lhs, rhs;
  logic              enough, found;

  // next older slot, wrapping below zero
  assign prev_ptr = (rd_ptr == '0) ? PTR_LAST : rd_ptr - PTR_W'(1);
  assign rd_day   = win_days[prev_ptr];
  assign rd_temp  = win_temps[prev_ptr];

  // signed day distance; negative (out of order) never stops the walk
  assign gap = {1'b0, day_r} - {1'b0, rd_day};

  assign status.gap_stop = !gap[DAY_W] && (gap[DAY_W-1:0] > DAY_W'(tsd_pkg::MAX_DAY_SPAN));
  assign status.walk_en  = (fill_count >= FILL_W'(WINDOW_LENGTH - 1)) && (temperature != '0);
  assign status.out_free = !out_valid || out_ready;

  // exact test: temp * count > sum + thr * count
  assign thr    = fahrenheit_mode ? tsd_pkg::THRESH_F : tsd_pkg::THRESH_C;
  assign lhs    = CMP_W'(temp_r) * CMP_W'(count);
  assign rhs    = CMP_W'(sum) + CMP_W'(thr) * CMP_W'(count);
  assign enough = {{(32-CNT_W){1'b0}}, count} >= 32'(tsd_pkg::MIN_COUNT);
  assign found  = enough && (lhs > rhs);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win_days[wr_ptr]  <= day_number;
      win_temps[wr_ptr] <= temperature;
      day_r  <= day_number;
      temp_r <= temperature;
      rd_ptr <= wr_ptr;
      sum    <= '0;
      count  <= '0;
    end else if (cmd.step) begin
      rd_ptr <= prev_ptr;
      if (!status.gap_stop && rd_temp != '0) begin
        sum   <= sum + SUM_W'(rd_temp);
        count <= count + CNT_W'(1);
      end
    end
    if (cmd.finish) begin
      shift_found <= found;
      shift_day   <= found ? day_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr          <= '0;
      fill_count      <= '0;
      fahrenheit_mode <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        fahrenheit_mode <= cfg_data;
      end
      if (cmd.load) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
        if (fill_count != FILL_MAX) begin
          fill_count <= fill_count + FILL_W'(1);
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/temperature_shift_detector_unit.sv @@
// Top level of the temperature shift detector: controller plus datapath.
//
// Takes one daily reading per item (day number, temperature in hundredths)
// and returns exactly one result item per input. Once WINDOW_LENGTH readings
// are held and the newest is nonzero, the block steps back through the
// earlier readings one per cycle, newest first, stopping at the first one
// more than six days older and skipping zero readings; with at least four
// counted it flags a shift when the newest reading exceeds their mean by
// more than 0.40 (fahrenheit_mode=1) or 0.20 degrees, compared exactly as
// temp*count > sum + thr*count. An item goes straight to delivery when no
// walk is needed and through the walk over the stored window otherwise.
// Items are handled one at a time; a result waiting in the output register
// does not hold off the next item, which stalls only at delivery. The
// configuration register is written on any cfg_valid (cfg_ready is always
// high) and should change only while the block is idle. No clearing pass
// is needed after reset.
module temperature_shift_detector_unit #(
  parameter int WINDOW_LENGTH = tsd_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data,
  // reading items
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tsd_pkg::DAY_W-1:0]  day_number,
  input  logic [tsd_pkg::TEMP_W-1:0] temperature,
  // result items
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       shift_found,
  output logic [tsd_pkg::DAY_W-1:0]  shift_day
);

  tsd_pkg::tsd_cmd_t    cmd;
  tsd_pkg::tsd_status_t status;

  // register write never stalls
  assign cfg_ready = 1'b1;

  tsd_ctrl #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tsd_datapath #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .day_number  (day_number),
    .temperature (temperature),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .shift_found (shift_found),
    .shift_day   (shift_day)
  );

endmodule
